[src/rgc_pkg.sv]
package rgc_pkg;

    localparam int CTR_W = 64;
    localparam int NUM_CTRS = 32;
    localparam int CTR_IDX_W = $clog2(NUM_CTRS);
    localparam int NUM_INV = 6;

    localparam int PC_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int FUNC_W = 3;
    localparam int IC_FLAGS_W = 7;
    localparam int DC_FLAGS_W = 13;
    localparam int CORE_FLAGS_W = 3;
    localparam int SEL_W = 6;
    localparam int VALUE_W = 64;

    localparam logic [SEL_W-1:0] SEL_EXCL_SUM = SEL_W'(NUM_CTRS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INIT   = 3'd0,
        FUNC_REGION = 3'd1,
        FUNC_TICK   = 3'd2,
        FUNC_SAMPLE = 3'd3,
        FUNC_WB     = 3'd4
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLLECT_ENABLE = 3'd0,
        CFG_START_PC_SET   = 3'd1,
        CFG_START_PC       = 3'd2,
        CFG_END_PC_SET     = 3'd3,
        CFG_END_PC         = 3'd4
    } cfg_idx_t;

    // counter slots
    localparam int CTR_CYCLES      = 0;
    localparam int CTR_WB_OBS      = 1;
    localparam int CTR_IC_ACCESS   = 2;
    localparam int CTR_IC_HIT      = 3;
    localparam int CTR_IC_MISS     = 4;
    localparam int CTR_DC_ACCESS   = 9;
    localparam int CTR_DC_LOAD     = 10;
    localparam int CTR_DC_STORE    = 11;
    localparam int CTR_DC_HIT      = 12;
    localparam int CTR_DC_MISS     = 13;
    localparam int CTR_LOAD_HIT    = 14;
    localparam int CTR_LOAD_MISS   = 15;
    localparam int CTR_STORE_HIT   = 16;
    localparam int CTR_STORE_MISS  = 17;
    localparam int CTR_DC_REFILL   = 18;
    localparam int CTR_X_DCACHE    = 26;
    localparam int CTR_X_DIV       = 27;
    localparam int CTR_X_BRANCH    = 28;
    localparam int CTR_X_DEP       = 29;
    localparam int CTR_X_ICACHE    = 30;
    localparam int CTR_X_OTHER     = 31;

    // flag bits
    localparam int IC_TOTAL_STALL  = 6;
    localparam int DC_LOAD         = 1;
    localparam int DC_STORE        = 2;
    localparam int DC_HIT          = 3;
    localparam int DC_MISS         = 4;
    localparam int DC_REFILL_START = 5;
    localparam int DC_TOTAL_STALL  = 12;
    localparam int CORE_DIV        = 0;
    localparam int CORE_BRANCH     = 1;
    localparam int CORE_DEP        = 2;

    typedef struct packed {
        logic            collect_enable;
        logic            start_pc_set;
        logic [PC_W-1:0] start_pc;
        logic            end_pc_set;
        logic [PC_W-1:0] end_pc;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic tick;
        logic sample;
        logic wb_bump;
    } ctl_t;

    typedef struct packed {
        logic collecting_now;
        logic region_active;
        logic region_valid;
    } status_t;

    // signed change of (a - b - c), widened to a counter
    function automatic logic [CTR_W-1:0] delta3(input logic a, input logic b, input logic c);
        logic signed [2:0] d;
        d = signed'({2'b00, a}) - signed'({2'b00, b}) - signed'({2'b00, c});
        return {{(CTR_W-3){d[2]}}, d};
    endfunction

endpackage

[src/rgc_ctrl.sv]
module rgc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  rgc_pkg::func_t         func,
    input  logic                   wb_valid,
    input  logic [rgc_pkg::PC_W-1:0] wb_pc,
    input  rgc_pkg::cfg_t          cfg,
    output rgc_pkg::ctl_t          ctl,
    output rgc_pkg::status_t       status
);

    logic enable_reg;
    logic enable_next;
    logic requested_reg;
    logic requested_next;
    logic open_reg;
    logic open_next;
    logic started_reg;
    logic started_next;
    logic ended_reg;
    logic ended_next;
    logic collecting;
    logic hit_start;
    logic hit_end;
    logic req_init;
    rgc_pkg::ctl_t ctl_raw;

    assign collecting = enable_reg && open_reg;
    assign hit_start  = (wb_pc == cfg.start_pc);
    assign hit_end    = (wb_pc == cfg.end_pc);
    assign req_init   = cfg.start_pc_set || cfg.end_pc_set;

    always_comb
    begin
        enable_next    = enable_reg;
        requested_next = requested_reg;
        open_next      = open_reg;
        started_next   = started_reg;
        ended_next     = ended_reg;
        ctl_raw        = '0;
        case (func)
            rgc_pkg::FUNC_INIT:
            begin
                requested_next = req_init;
                enable_next    = cfg.collect_enable
                                 && (cfg.start_pc_set == cfg.end_pc_set)
                                 && !(req_init && (cfg.start_pc == cfg.end_pc));
                open_next      = !req_init;
                started_next   = !req_init;
                ended_next     = 1'b0;
                ctl_raw.clear  = 1'b1;
            end
            rgc_pkg::FUNC_REGION:
            begin
                if (enable_reg && requested_reg && wb_valid)
                begin
                    if (!started_reg && hit_start)
                    begin
                        ctl_raw.clear = 1'b1;
                        started_next  = 1'b1;
                        open_next     = 1'b1;
                    end
                    else if (open_reg && hit_end)
                    begin
                        open_next  = 1'b0;
                        ended_next = 1'b1;
                    end
                end
            end
            rgc_pkg::FUNC_TICK:
            begin
                ctl_raw.tick = collecting;
            end
            rgc_pkg::FUNC_SAMPLE:
            begin
                ctl_raw.sample = collecting;
            end
            rgc_pkg::FUNC_WB:
            begin
                ctl_raw.wb_bump = collecting && wb_valid
                                  && !(requested_reg && (hit_start || hit_end));
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctl                   = fire ? ctl_raw : '0;
        status.collecting_now = enable_next && open_next;
        status.region_active  = open_next;
        status.region_valid   = !requested_next || (started_next && ended_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            requested_reg <= 1'b0;
            open_reg      <= 1'b1;
            started_reg   <= 1'b1;
            ended_reg     <= 1'b0;
        end
        else if (fire)
        begin
            enable_reg    <= enable_next;
            requested_reg <= requested_next;
            open_reg      <= open_next;
            started_reg   <= started_next;
            ended_reg     <= ended_next;
        end
    end

endmodule

[src/rgc_bank.sv]
module rgc_bank (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rgc_pkg::ctl_t                    ctl,
    input  logic [rgc_pkg::IC_FLAGS_W-1:0]   icache_flags,
    input  logic [rgc_pkg::DC_FLAGS_W-1:0]   dcache_flags,
    input  logic [rgc_pkg::CORE_FLAGS_W-1:0] core_stall_flags,
    input  logic [rgc_pkg::SEL_W-1:0]        counter_index,
    output logic [rgc_pkg::CTR_W-1:0]        counter_value,
    output logic                             invariants_ok
);

    logic [rgc_pkg::CTR_W-1:0]    ctr_reg  [rgc_pkg::NUM_CTRS];
    logic [rgc_pkg::CTR_W-1:0]    ctr_next [rgc_pkg::NUM_CTRS];
    logic [rgc_pkg::CTR_W-1:0]    diff_reg  [rgc_pkg::NUM_INV];
    logic [rgc_pkg::CTR_W-1:0]    diff_next [rgc_pkg::NUM_INV];
    logic [rgc_pkg::CTR_W-1:0]    diff_delta [rgc_pkg::NUM_INV];
    logic [rgc_pkg::CTR_W-1:0]    excl_reg;
    logic [rgc_pkg::CTR_W-1:0]    excl_next;
    logic [rgc_pkg::NUM_CTRS-1:0] inc;
    logic                         excl_inc;
    logic                         dload;
    logic                         dstore;
    logic                         dhit;
    logic                         dmiss;

    assign dload  = dcache_flags[rgc_pkg::DC_LOAD];
    assign dstore = dcache_flags[rgc_pkg::DC_STORE];
    assign dhit   = dcache_flags[rgc_pkg::DC_HIT];
    assign dmiss  = dcache_flags[rgc_pkg::DC_MISS];

    always_comb
    begin
        inc = '0;
        inc[rgc_pkg::CTR_CYCLES] = ctl.tick;
        inc[rgc_pkg::CTR_WB_OBS] = ctl.wb_bump;
        if (ctl.sample)
        begin
            for (int b = 0; b < rgc_pkg::IC_FLAGS_W; b++)
            begin
                inc[rgc_pkg::CTR_IC_ACCESS + b] = icache_flags[b];
            end
            for (int b = 0; b <= rgc_pkg::DC_MISS; b++)
            begin
                inc[rgc_pkg::CTR_DC_ACCESS + b] = dcache_flags[b];
            end
            inc[rgc_pkg::CTR_LOAD_HIT]   = dhit && dload;
            inc[rgc_pkg::CTR_LOAD_MISS]  = dmiss && dload;
            inc[rgc_pkg::CTR_STORE_HIT]  = dhit && dstore;
            inc[rgc_pkg::CTR_STORE_MISS] = dmiss && dstore;
            for (int b = rgc_pkg::DC_REFILL_START; b < rgc_pkg::DC_FLAGS_W; b++)
            begin
                inc[rgc_pkg::CTR_DC_REFILL + b - rgc_pkg::DC_REFILL_START] = dcache_flags[b];
            end
            // one exclusive stall cause by priority
            if (dcache_flags[rgc_pkg::DC_TOTAL_STALL])
            begin
                inc[rgc_pkg::CTR_X_DCACHE] = 1'b1;
            end
            else if (core_stall_flags[rgc_pkg::CORE_DIV])
            begin
                inc[rgc_pkg::CTR_X_DIV] = 1'b1;
            end
            else if (core_stall_flags[rgc_pkg::CORE_BRANCH])
            begin
                inc[rgc_pkg::CTR_X_BRANCH] = 1'b1;
            end
            else if (core_stall_flags[rgc_pkg::CORE_DEP])
            begin
                inc[rgc_pkg::CTR_X_DEP] = 1'b1;
            end
            else if (icache_flags[rgc_pkg::IC_TOTAL_STALL])
            begin
                inc[rgc_pkg::CTR_X_ICACHE] = 1'b1;
            end
            else
            begin
                inc[rgc_pkg::CTR_X_OTHER] = 1'b1;
            end
        end
    end

    assign excl_inc = |inc[rgc_pkg::CTR_X_OTHER:rgc_pkg::CTR_X_DCACHE];

    always_comb
    begin
        for (int i = 0; i < rgc_pkg::NUM_CTRS; i++)
        begin
            ctr_next[i] = ctl.clear ? '0 : ctr_reg[i] + rgc_pkg::CTR_W'(inc[i]);
        end
        excl_next = ctl.clear ? '0 : excl_reg + rgc_pkg::CTR_W'(excl_inc);
    end

    // running differences, each zero while its identity holds
    always_comb
    begin
        diff_delta[0] = rgc_pkg::delta3(inc[rgc_pkg::CTR_IC_ACCESS],
                                        inc[rgc_pkg::CTR_IC_HIT], inc[rgc_pkg::CTR_IC_MISS]);
        diff_delta[1] = rgc_pkg::delta3(inc[rgc_pkg::CTR_DC_ACCESS],
                                        inc[rgc_pkg::CTR_DC_LOAD], inc[rgc_pkg::CTR_DC_STORE]);
        diff_delta[2] = rgc_pkg::delta3(inc[rgc_pkg::CTR_DC_ACCESS],
                                        inc[rgc_pkg::CTR_DC_HIT], inc[rgc_pkg::CTR_DC_MISS]);
        diff_delta[3] = rgc_pkg::delta3(inc[rgc_pkg::CTR_DC_LOAD],
                                        inc[rgc_pkg::CTR_LOAD_HIT], inc[rgc_pkg::CTR_LOAD_MISS]);
        diff_delta[4] = rgc_pkg::delta3(inc[rgc_pkg::CTR_DC_STORE],
                                        inc[rgc_pkg::CTR_STORE_HIT], inc[rgc_pkg::CTR_STORE_MISS]);
        diff_delta[5] = rgc_pkg::delta3(excl_inc, inc[rgc_pkg::CTR_CYCLES], 1'b0);
        invariants_ok = 1'b1;
        for (int k = 0; k < rgc_pkg::NUM_INV; k++)
        begin
            diff_next[k]  = ctl.clear ? '0 : diff_reg[k] + diff_delta[k];
            invariants_ok = invariants_ok && (diff_next[k] == '0);
        end
    end

    always_comb
    begin
        if (counter_index < rgc_pkg::SEL_W'(rgc_pkg::NUM_CTRS))
        begin
            counter_value = ctr_next[counter_index[rgc_pkg::CTR_IDX_W-1:0]];
        end
        else if (counter_index == rgc_pkg::SEL_EXCL_SUM)
        begin
            counter_value = excl_next;
        end
        else
        begin
            counter_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rgc_pkg::NUM_CTRS; i++)
            begin
                ctr_reg[i] <= '0;
            end
            for (int k = 0; k < rgc_pkg::NUM_INV; k++)
            begin
                diff_reg[k] <= '0;
            end
            excl_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < rgc_pkg::NUM_CTRS; i++)
            begin
                ctr_reg[i] <= ctr_next[i];
            end
            for (int k = 0; k < rgc_pkg::NUM_INV; k++)
            begin
                diff_reg[k] <= diff_next[k];
            end
            excl_reg <= excl_next;
        end
    end

endmodule

[src/roi_gated_cache_event_counters.sv]
// Region-of-interest gated cache event counters.
// Input channel (in_valid/in_stall) carries one beat per event: init, region
// update, cycle tick, event sample or writeback observation, selected by func.
// Output channel (out_valid/out_stall) returns one beat per input beat: the
// selected counter (index 32 gives the exclusive stall sum), region status and
// the invariant check, all as seen after that beat took effect.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect at the next init beat (enable and region decisions); start and
// end PC are compared live, so write them only while the block is idle.
// From input acceptance to out_valid a beat passes through the input register and
// then the result register, which loads when the beat fires, with all counter
// updates done in between.
// Throughput is one beat per cycle while out_stall is low; the counter bank updates all 32 counters
// in parallel, and invariant and exclusive-sum tracking is incremental.
// When out_stall is high with a valid result, the result register holds and the input register
// absorbs one more beat before in_stall rises.
// Reset clears all counters and config registers; the region starts open and
// collection disabled until an init beat.
module roi_gated_cache_event_counters (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rgc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rgc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rgc_pkg::FUNC_W-1:0]           func,
    input  logic                                 wb_valid,
    input  logic [rgc_pkg::PC_W-1:0]             wb_pc,
    input  logic [rgc_pkg::IC_FLAGS_W-1:0]       icache_flags,
    input  logic [rgc_pkg::DC_FLAGS_W-1:0]       dcache_flags,
    input  logic [rgc_pkg::CORE_FLAGS_W-1:0]     core_stall_flags,
    input  logic [rgc_pkg::SEL_W-1:0]            counter_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rgc_pkg::VALUE_W-1:0]          counter_value,
    output logic                                 collecting_now,
    output logic                                 region_active,
    output logic                                 region_valid,
    output logic                                 invariants_ok
);

    rgc_pkg::cfg_t cfg_reg;

    logic                               s1_valid_reg;
    rgc_pkg::func_t                     s1_func_reg;
    logic                               s1_wb_valid_reg;
    logic [rgc_pkg::PC_W-1:0]           s1_wb_pc_reg;
    logic [rgc_pkg::IC_FLAGS_W-1:0]     s1_ic_reg;
    logic [rgc_pkg::DC_FLAGS_W-1:0]     s1_dc_reg;
    logic [rgc_pkg::CORE_FLAGS_W-1:0]   s1_core_reg;
    logic [rgc_pkg::SEL_W-1:0]          s1_index_reg;

    logic                               out_valid_reg;
    logic [rgc_pkg::VALUE_W-1:0]        value_reg;
    rgc_pkg::status_t                   status_reg;
    logic                               inv_reg;

    logic                               advance;
    logic                               fire;
    logic                               in_take;
    rgc_pkg::ctl_t                      ctl;
    rgc_pkg::status_t                   status;
    logic [rgc_pkg::CTR_W-1:0]          bank_value;
    logic                               bank_inv_ok;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgc_pkg::CFG_COLLECT_ENABLE: cfg_reg.collect_enable <= cfg_data[0];
                rgc_pkg::CFG_START_PC_SET:   cfg_reg.start_pc_set   <= cfg_data[0];
                rgc_pkg::CFG_START_PC:       cfg_reg.start_pc       <= cfg_data;
                rgc_pkg::CFG_END_PC_SET:     cfg_reg.end_pc_set     <= cfg_data[0];
                rgc_pkg::CFG_END_PC:         cfg_reg.end_pc         <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg     <= rgc_pkg::func_t'(func);
            s1_wb_valid_reg <= wb_valid;
            s1_wb_pc_reg    <= wb_pc;
            s1_ic_reg       <= icache_flags;
            s1_dc_reg       <= dcache_flags;
            s1_core_reg     <= core_stall_flags;
            s1_index_reg    <= counter_index;
        end
    end

    rgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .func     (s1_func_reg),
        .wb_valid (s1_wb_valid_reg),
        .wb_pc    (s1_wb_pc_reg),
        .cfg      (cfg_reg),
        .ctl      (ctl),
        .status   (status)
    );

    rgc_bank u_bank (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .icache_flags     (s1_ic_reg),
        .dcache_flags     (s1_dc_reg),
        .core_stall_flags (s1_core_reg),
        .counter_index    (s1_index_reg),
        .counter_value    (bank_value),
        .invariants_ok    (bank_inv_ok)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            value_reg  <= rgc_pkg::VALUE_W'(bank_value);
            status_reg <= status;
            inv_reg    <= bank_inv_ok;
        end
    end

    assign out_valid      = out_valid_reg;
    assign counter_value  = value_reg;
    assign collecting_now = status_reg.collecting_now;
    assign region_active  = status_reg.region_active;
    assign region_valid   = status_reg.region_valid;
    assign invariants_ok  = inv_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_init_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_func_reg == rgc_pkg::FUNC_INIT) |=> (out_valid && invariants_ok))
        else $error("init beat did not produce a consistent result");

    a_init_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_func_reg == rgc_pkg::FUNC_INIT) |=> (counter_value == '0))
        else $error("counter nonzero right after init");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result appeared without a staged beat");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rgc_pkg::*;

    localparam int LIMIT = 500000;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
    localparam int IC_ACCESS = 0;
    localparam int IC_HIT = 1;
    localparam int IC_MISS = 2;
    localparam int DC_ACCESS = 0;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               collecting;
        logic               active;
        logic               valid;
        logic               inv_ok;
    } report_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [FUNC_W-1:0]       func;
    logic                    wb_valid;
    logic [PC_W-1:0]         wb_pc;
    logic [IC_FLAGS_W-1:0]   icache_flags;
    logic [DC_FLAGS_W-1:0]   dcache_flags;
    logic [CORE_FLAGS_W-1:0] core_stall_flags;
    logic [SEL_W-1:0]        counter_index;
    logic                    out_valid;
    logic                    out_stall;
    logic [VALUE_W-1:0]      counter_value;
    logic                    collecting_now;
    logic                    region_active;
    logic                    region_valid;
    logic                    invariants_ok;

    // predicted monitor state
    cfg_t             shadow = '0;
    logic [CTR_W-1:0] tally [NUM_CTRS];
    logic             count_enabled = 1'b0;
    logic             win_requested = 1'b0;
    logic             win_open = 1'b1;
    logic             win_started = 1'b1;
    logic             win_ended = 1'b0;

    report_t pending_reports[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      tx_burst = 1'b0;
    bit      rx_burst = 1'b0;
    bit      tidy = 1'b0;

    roi_gated_cache_event_counters dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .wb_valid         (wb_valid),
        .wb_pc            (wb_pc),
        .icache_flags     (icache_flags),
        .dcache_flags     (dcache_flags),
        .core_stall_flags (core_stall_flags),
        .counter_index    (counter_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .counter_value    (counter_value),
        .collecting_now   (collecting_now),
        .region_active    (region_active),
        .region_valid     (region_valid),
        .invariants_ok    (invariants_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic int pick_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [PC_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CTR_W-1:0] exclusive_total();
        logic [CTR_W-1:0] s;
        s = '0;
        for (int k = CTR_X_DCACHE; k <= CTR_X_OTHER; k++)
            s += tally[k];
        return s;
    endfunction

    function automatic report_t advance_counters(
        input logic [FUNC_W-1:0]       f,
        input logic                    wbv,
        input logic [PC_W-1:0]         pc,
        input logic [IC_FLAGS_W-1:0]   ic,
        input logic [DC_FLAGS_W-1:0]   dc,
        input logic [CORE_FLAGS_W-1:0] core,
        input logic [SEL_W-1:0]        idx
    );
        report_t          r;
        logic [CTR_W-1:0] xsum;
        int               cause;
        case (f)
            FUNC_INIT:
            begin
                win_requested = shadow.start_pc_set | shadow.end_pc_set;
                count_enabled = shadow.collect_enable;
                if (shadow.start_pc_set != shadow.end_pc_set ||
                    (win_requested && shadow.start_pc == shadow.end_pc))
                    count_enabled = 1'b0;
                win_open = !win_requested;
                win_started = !win_requested;
                win_ended = 1'b0;
                foreach (tally[k])
                    tally[k] = '0;
            end
            FUNC_REGION:
            begin
                if (count_enabled && win_requested && wbv)
                begin
                    if (!win_started && pc == shadow.start_pc)
                    begin
                        foreach (tally[k])
                            tally[k] = '0;
                        win_started = 1'b1;
                        win_open = 1'b1;
                    end
                    else if (win_open && pc == shadow.end_pc)
                    begin
                        win_open = 1'b0;
                        win_ended = 1'b1;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (count_enabled && win_open)
                    tally[CTR_CYCLES] += 1;
            end
            FUNC_SAMPLE:
            begin
                if (count_enabled && win_open)
                begin
                    for (int b = 0; b < IC_FLAGS_W; b++)
                        tally[CTR_IC_ACCESS + b] += ic[b];
                    for (int b = 0; b <= DC_MISS; b++)
                        tally[CTR_DC_ACCESS + b] += dc[b];
                    tally[CTR_LOAD_HIT] += dc[DC_HIT] & dc[DC_LOAD];
                    tally[CTR_LOAD_MISS] += dc[DC_MISS] & dc[DC_LOAD];
                    tally[CTR_STORE_HIT] += dc[DC_HIT] & dc[DC_STORE];
                    tally[CTR_STORE_MISS] += dc[DC_MISS] & dc[DC_STORE];
                    for (int b = DC_REFILL_START; b < DC_FLAGS_W; b++)
                        tally[CTR_DC_REFILL + b - DC_REFILL_START] += dc[b];
                    if (dc[DC_TOTAL_STALL])
                        cause = CTR_X_DCACHE;
                    else if (core[CORE_DIV])
                        cause = CTR_X_DIV;
                    else if (core[CORE_BRANCH])
                        cause = CTR_X_BRANCH;
                    else if (core[CORE_DEP])
                        cause = CTR_X_DEP;
                    else if (ic[IC_TOTAL_STALL])
                        cause = CTR_X_ICACHE;
                    else
                        cause = CTR_X_OTHER;
                    tally[cause] += 1;
                end
            end
            FUNC_WB:
            begin
                if (count_enabled && win_open && wbv &&
                    !(win_requested && (pc == shadow.start_pc || pc == shadow.end_pc)))
                    tally[CTR_WB_OBS] += 1;
            end
            default:
            begin
            end
        endcase

        xsum = exclusive_total();
        if (idx < NUM_CTRS)
            r.value = tally[idx];
        else if (idx == SEL_EXCL_SUM)
            r.value = xsum;
        else
            r.value = '0;
        r.collecting = count_enabled && win_open;
        r.active = win_open;
        r.valid = !win_requested || (win_started && win_ended);
        r.inv_ok = tally[CTR_IC_ACCESS] == tally[CTR_IC_HIT] + tally[CTR_IC_MISS] &&
                   tally[CTR_DC_ACCESS] == tally[CTR_DC_LOAD] + tally[CTR_DC_STORE] &&
                   tally[CTR_DC_ACCESS] == tally[CTR_DC_HIT] + tally[CTR_DC_MISS] &&
                   tally[CTR_DC_LOAD] == tally[CTR_LOAD_HIT] + tally[CTR_LOAD_MISS] &&
                   tally[CTR_DC_STORE] == tally[CTR_STORE_HIT] + tally[CTR_STORE_MISS] &&
                   xsum == tally[CTR_CYCLES];
        return r;
    endfunction

    // result side: random stall per beat, compare against oldest prediction
    initial
    begin
        int      hold;
        report_t want;
        out_stall <= 1'b0;
        hold = pick_gap(rx_burst);
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (counter_value !== want.value)
                    begin
                        $error("counter_value: expected %h, got %h", want.value, counter_value);
                        mismatches++;
                    end
                    if (collecting_now !== want.collecting)
                    begin
                        $error("collecting_now: expected %b, got %b",
                               want.collecting, collecting_now);
                        mismatches++;
                    end
                    if (region_active !== want.active)
                    begin
                        $error("region_active: expected %b, got %b", want.active, region_active);
                        mismatches++;
                    end
                    if (region_valid !== want.valid)
                    begin
                        $error("region_valid: expected %b, got %b", want.valid, region_valid);
                        mismatches++;
                    end
                    if (invariants_ok !== want.inv_ok)
                    begin
                        $error("invariants_ok: expected %b, got %b", want.inv_ok, invariants_ok);
                        mismatches++;
                    end
                end
                hold = pick_gap(rx_burst);
            end
            else if (out_valid && hold > 0)
            begin
                hold--;
            end
            out_stall <= (hold > 0);
        end
    end

    task automatic send_beat(
        input logic [FUNC_W-1:0]       f,
        input logic                    wbv,
        input logic [PC_W-1:0]         pc,
        input logic [IC_FLAGS_W-1:0]   ic,
        input logic [DC_FLAGS_W-1:0]   dc,
        input logic [CORE_FLAGS_W-1:0] core,
        input logic [SEL_W-1:0]        idx
    );
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        wb_valid <= wbv;
        wb_pc <= pc;
        icache_flags <= ic;
        dcache_flags <= dc;
        core_stall_flags <= core;
        counter_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        pending_reports.push_back(advance_counters(f, wbv, pc, ic, dc, core, idx));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic write_word(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input logic ce, input logic ss, input logic [PC_W-1:0] spc,
                              input logic es, input logic [PC_W-1:0] epc);
        logic [CFG_DATA_W-1:0] junk;
        junk = rand_word();
        write_word(CFG_COLLECT_ENABLE, {junk[CFG_DATA_W-1:1], ce});
        junk = rand_word();
        write_word(CFG_START_PC_SET, {junk[CFG_DATA_W-1:1], ss});
        write_word(CFG_START_PC, spc);
        junk = rand_word();
        write_word(CFG_END_PC_SET, {junk[CFG_DATA_W-1:1], es});
        write_word(CFG_END_PC, epc);
        // unmapped indexes must be ignored
        for (int k = CFG_SPARE; k < 2 ** CFG_IDX_W; k++)
            write_word(CFG_IDX_W'(k), rand_word());
        cfg_we <= 1'b0;
        shadow.collect_enable = ce;
        shadow.start_pc_set = ss;
        shadow.start_pc = spc;
        shadow.end_pc_set = es;
        shadow.end_pc = epc;
    endtask

    function automatic logic [SEL_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 85)
            return SEL_W'($urandom_range(0, NUM_CTRS));
        return SEL_W'($urandom_range(0, 2 ** SEL_W - 1));
    endfunction

    function automatic logic [PC_W-1:0] pick_pc();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return shadow.start_pc;
        if (r < 4)
            return shadow.end_pc;
        if (r == 4)
            return '0;
        if (r == 5)
            return '1;
        return rand_word();
    endfunction

    function automatic logic [IC_FLAGS_W-1:0] pick_ic();
        logic [IC_FLAGS_W-1:0] v;
        logic                  h;
        v = IC_FLAGS_W'($urandom);
        if (tidy)
        begin
            h = $urandom_range(0, 1);
            v[IC_HIT] = v[IC_ACCESS] & h;
            v[IC_MISS] = v[IC_ACCESS] & ~h;
        end
        return v;
    endfunction

    function automatic logic [DC_FLAGS_W-1:0] pick_dc();
        logic [DC_FLAGS_W-1:0] v;
        logic                  ld;
        logic                  h;
        v = DC_FLAGS_W'($urandom);
        if (tidy)
        begin
            ld = $urandom_range(0, 1);
            h = $urandom_range(0, 1);
            v[DC_LOAD] = v[DC_ACCESS] & ld;
            v[DC_STORE] = v[DC_ACCESS] & ~ld;
            v[DC_HIT] = v[DC_ACCESS] & h;
            v[DC_MISS] = v[DC_ACCESS] & ~h;
        end
        return v;
    endfunction

    task automatic send_random_item();
        int                r;
        logic [FUNC_W-1:0] f;
        logic [PC_W-1:0]   pc;
        logic              wbv;
        r = $urandom_range(0, 99);
        pc = pick_pc();
        wbv = $urandom_range(0, 1);
        if (r < 32)
        begin
            f = FUNC_TICK;
        end
        else if (r < 70)
        begin
            f = FUNC_SAMPLE;
        end
        else if (r < 88)
        begin
            f = FUNC_WB;
            wbv = $urandom_range(0, 3) != 0;
        end
        else if (r < 95)
        begin
            f = FUNC_REGION;
            r = $urandom_range(0, 11);
            pc = (r == 0) ? shadow.start_pc : (r == 1) ? shadow.end_pc : rand_word();
        end
        else if (r < 99 || tidy)
        begin
            f = FUNC_SPARE + FUNC_W'($urandom_range(0, 2));
        end
        else
        begin
            f = FUNC_INIT;
        end
        send_beat(f, wbv, pc, pick_ic(), pick_dc(), CORE_FLAGS_W'($urandom), pick_index());
        // paired tick keeps the exclusive sum in step with cycles
        if (tidy && f == FUNC_SAMPLE)
            send_beat(FUNC_TICK, $urandom_range(0, 1), rand_word(), pick_ic(), pick_dc(),
                      CORE_FLAGS_W'($urandom), pick_index());
    endtask

    task automatic test_reset_view();
        send_beat(FUNC_TICK, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
    endtask

    task automatic test_plain_counting();
        settle();
        set_config(1'b1, 1'b0, '0, 1'b0, '0);
        send_beat(FUNC_INIT, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_TICK, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_SAMPLE, 1'b1, '1, '1, '1, '1, SEL_W'(CTR_X_DCACHE));
        send_beat(FUNC_SAMPLE, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_X_OTHER));
        send_beat(FUNC_SAMPLE, 1'b0, '0, 7'h40, '0, 3'b001, SEL_W'(CTR_X_DIV));
        send_beat(FUNC_SAMPLE, 1'b0, '0, 7'h40, '0, 3'b110, SEL_W'(CTR_X_BRANCH));
        send_beat(FUNC_SAMPLE, 1'b0, '0, 7'h40, '0, 3'b100, SEL_W'(CTR_X_DEP));
        send_beat(FUNC_SAMPLE, 1'b0, '0, 7'h40, 13'h0fff, '0, SEL_W'(CTR_X_ICACHE));
        send_beat(FUNC_WB, 1'b1, rand_word(), '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_WB, 1'b0, '1, '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_TICK, 1'b0, '0, '0, '0, '0, SEL_EXCL_SUM);
        send_beat(FUNC_TICK, 1'b0, '0, '0, '0, '0, '1);
        for (int k = FUNC_SPARE; k < 2 ** FUNC_W; k++)
            send_beat(FUNC_W'(k), 1'b1, '1, '1, '1, '1, SEL_W'(CTR_CYCLES));
    endtask

    task automatic test_region_window();
        settle();
        set_config(1'b1, 1'b1, '0, 1'b1, '1);
        send_beat(FUNC_INIT, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_WB, 1'b1, 64'h1000, '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_REGION, 1'b1, '1, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_REGION, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_REGION, 1'b1, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_TICK, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
        send_beat(FUNC_WB, 1'b1, '0, '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_WB, 1'b1, '1, '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_WB, 1'b1, 64'h1000, '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_REGION, 1'b1, '1, '0, '0, '0, SEL_W'(CTR_WB_OBS));
        send_beat(FUNC_TICK, 1'b0, '0, '0, '0, '0, SEL_W'(CTR_CYCLES));
    endtask

    task automatic run_window(input int kind, input int n_items);
        logic           ce;
        logic           ss;
        logic           es;
        logic [PC_W-1:0] spc;
        logic [PC_W-1:0] epc;
        ce = 1'b1;
        ss = 1'b1;
        es = 1'b1;
        spc = rand_word();
        epc = rand_word();
        if (epc == spc)
            epc[0] = ~epc[0];
        case (kind)
            0:
            begin
                ss = 1'b0;
                es = 1'b0;
            end
            2:
            begin
                spc = $urandom_range(0, 1) ? '0 : '1;
                epc = ~spc;
            end
            3:
            begin
                ce = 1'b0;
                ss = $urandom_range(0, 1);
                es = $urandom_range(0, 1);
            end
            4:
            begin
                ss = $urandom_range(0, 1);
                es = ~ss;
            end
            5:
            begin
                epc = spc;
            end
            default:
            begin
            end
        endcase
        settle();
        set_config(ce, ss, spc, es, epc);
        tx_burst = $urandom_range(0, 3) == 0;
        rx_burst = $urandom_range(0, 3) == 0;
        tidy = $urandom_range(0, 2) == 0;
        send_beat(FUNC_INIT, $urandom_range(0, 1), rand_word(), pick_ic(), pick_dc(),
                  CORE_FLAGS_W'($urandom), pick_index());
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 8)
            begin
                send_beat(FUNC_REGION, 1'b1, spc, pick_ic(), pick_dc(),
                          CORE_FLAGS_W'($urandom), pick_index());
            end
            else if (i == n_items * 7 / 8)
            begin
                send_beat(FUNC_REGION, 1'b1, epc, pick_ic(), pick_dc(),
                          CORE_FLAGS_W'($urandom), pick_index());
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    settle();
                if ($urandom_range(0, 19) == 0)
                    tx_burst = !tx_burst;
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
                send_random_item();
            end
        end
    endtask

    task automatic test_random_windows();
        int kinds [8] = '{1, 2, 0, 1, 3, 4, 1, 5};
        for (int p = 0; p < 16; p++)
            run_window(kinds[p % 8], $urandom_range(80, 120));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= FUNC_TICK;
        wb_valid <= 1'b0;
        wb_pc <= '0;
        icache_flags <= '0;
        dcache_flags <= '0;
        core_stall_flags <= '0;
        counter_index <= '0;
        foreach (tally[k])
            tally[k] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_view();
        test_plain_counting();
        test_region_window();
        test_random_windows();

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
src/rgc_pkg.sv
src/rgc_ctrl.sv
src/rgc_bank.sv
src/roi_gated_cache_event_counters.sv
verif/tb.sv
